// File: hw/rtl/wsht_pkg.sv
// ----------------------------------------------------------------------------
// wsht_pkg
// Shared constants and types of the working-set hit tracker.
// ----------------------------------------------------------------------------
package wsht_pkg;

  localparam int WINDOW_MAX_DEF = 16;
  localparam int PAGE_BITS_DEF  = 8;

  localparam int CFG_W       = 5;
  localparam int PAGE_ID_W   = 8;
  localparam int HIT_TOTAL_W = 32;
  localparam int SET_SIZE_W  = 5;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 5'd4;

  // window lookup for the page at the head of the pipe
  typedef struct packed {
    logic                 hit;
    logic                 drop;
    logic [PAGE_ID_W-1:0] drop_page;
  } lookup_t;

endpackage

// File: hw/rtl/wsht_window.sv
// ----------------------------------------------------------------------------
// wsht_window
// Reference ring with oldest pointer and fill level; finds hit and drop.
// ----------------------------------------------------------------------------
module wsht_window #(
  parameter int WINDOW_MAX = wsht_pkg::WINDOW_MAX_DEF,
  parameter int PAGE_BITS  = wsht_pkg::PAGE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [wsht_pkg::CFG_W-1:0] cfg_data,
  input  logic                       step,
  input  logic [PAGE_BITS-1:0]       page,
  output wsht_pkg::lookup_t          look
);
  import wsht_pkg::*;

  localparam int IDX_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FILL_W = $clog2(WINDOW_MAX + 1);
  localparam int SW     = (FILL_W > CFG_W) ? FILL_W : CFG_W;
  localparam int OFS_W  = IDX_W + 2;

  logic [PAGE_BITS-1:0] ring_r [WINDOW_MAX];
  logic [IDX_W-1:0]     oldest_r;
  logic [FILL_W-1:0]    fill_r;
  logic [CFG_W-1:0]     size_r;

  logic [SW-1:0]        size_ext;
  logic [FILL_W-1:0]    eff_size;
  logic                 full;
  logic [PAGE_BITS-1:0] old_page;
  logic [WINDOW_MAX-1:0] in_win;
  logic [WINDOW_MAX-1:0] match;
  logic [WINDOW_MAX-1:0] other;
  logic [OFS_W-1:0]     slot_sum;
  logic [IDX_W-1:0]     slot;

  always_comb begin
    size_ext = SW'(size_r);
    if (size_ext == '0) begin
      eff_size = FILL_W'(1);
    end else if (size_ext > SW'(WINDOW_MAX)) begin
      eff_size = FILL_W'(WINDOW_MAX);
    end else begin
      eff_size = FILL_W'(size_ext);
    end
  end

  assign full     = fill_r >= eff_size;
  assign old_page = ring_r[oldest_r];

  always_comb begin
    logic [OFS_W-1:0] ofs;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (OFS_W'(i) >= OFS_W'(oldest_r)) begin
        ofs = OFS_W'(i) - OFS_W'(oldest_r);
      end else begin
        ofs = OFS_W'(i) + OFS_W'(WINDOW_MAX) - OFS_W'(oldest_r);
      end
      in_win[i] = ofs < OFS_W'(fill_r);
      match[i]  = in_win[i] && (ring_r[i] == page);
      other[i]  = in_win[i] && (ring_r[i] == old_page) && (IDX_W'(i) != oldest_r);
    end
  end

  always_comb begin
    look.hit       = |match;
    look.drop      = full && !(|other) && (page != old_page);
    look.drop_page = look.drop ? PAGE_ID_W'(old_page) : '0;
  end

  always_comb begin
    slot_sum = OFS_W'(oldest_r) + OFS_W'(fill_r);
    if (slot_sum >= OFS_W'(WINDOW_MAX)) begin
      slot_sum = slot_sum - OFS_W'(WINDOW_MAX);
    end
    slot = IDX_W'(slot_sum);
  end

  always_ff @(posedge clk) begin
    if (step) begin
      ring_r[slot] <= page;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      fill_r   <= '0;
      size_r   <= WINDOW_SIZE_RST;
    end else if (cfg_we) begin
      oldest_r <= '0;
      fill_r   <= '0;
      size_r   <= cfg_data;
    end else if (step) begin
      if (full) begin
        oldest_r <= (oldest_r == IDX_W'(WINDOW_MAX - 1)) ? '0 : oldest_r + IDX_W'(1);
      end else begin
        fill_r <= fill_r + FILL_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/wsht_counters.sv
// ----------------------------------------------------------------------------
// wsht_counters
// Saturating hit total and distinct page count of the working set.
// ----------------------------------------------------------------------------
module wsht_counters #(
  parameter int WINDOW_MAX = wsht_pkg::WINDOW_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             step,
  input  wsht_pkg::lookup_t                look,
  output logic [wsht_pkg::HIT_TOTAL_W-1:0] hit_total_nxt,
  output logic [wsht_pkg::SET_SIZE_W-1:0]  set_size_nxt
);
  import wsht_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  logic [HIT_TOTAL_W-1:0] hit_total_r;
  logic [CNT_W-1:0]       distinct_r;
  logic [CNT_W-1:0]       distinct_nxt;

  always_comb begin
    hit_total_nxt = hit_total_r;
    if (look.hit && (hit_total_r != '1)) begin
      hit_total_nxt = hit_total_r + HIT_TOTAL_W'(1);
    end
    case ({!look.hit, look.drop})
      2'b10:   distinct_nxt = distinct_r + CNT_W'(1);
      2'b01:   distinct_nxt = distinct_r - CNT_W'(1);
      default: distinct_nxt = distinct_r;
    endcase
    set_size_nxt = SET_SIZE_W'(distinct_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_total_r <= '0;
      distinct_r  <= '0;
    end else if (cfg_we) begin
      distinct_r <= '0;
    end else if (step) begin
      hit_total_r <= hit_total_nxt;
      distinct_r  <= distinct_nxt;
    end
  end

endmodule

// File: hw/rtl/working_set_hit_tracker.sv
// ----------------------------------------------------------------------------
// working_set_hit_tracker
// Sliding-window working-set tracker over a stream of page references.
//
// in_*  : one page reference per beat, page_id in in_tdata.
// out_* : one result beat per reference: hit flag, saturating hit total,
//         working-set size, and the page that left the set, if any.
// cfg_* : window length write; every write empties the window and keeps
//         the hit total.
// Path: an accepted reference passes the input register, then the result
//       register, from which it is presented on out_*.
// Throughput: one reference per cycle while out_tready keeps the result
//          register free; the ring lookup, pointer update and counter
//          updates are all combinational between the two registers.
// Reset: window empty, length 4, hit total zero; ready at once.
// Stall: while out_tready is low the result holds; one more reference is
//        taken into the input register, then in_tready drops.
// ----------------------------------------------------------------------------
module working_set_hit_tracker #(
  parameter int WINDOW_MAX = wsht_pkg::WINDOW_MAX_DEF,
  parameter int PAGE_BITS  = wsht_pkg::PAGE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [wsht_pkg::CFG_W-1:0] cfg_wr_data,   // window_size
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,      // page_id[7:0]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // hit[0], hit_total[32:1], set_size[37:33], dropped_valid[38],
  // dropped_page[46:39], zero[47]
  output logic [47:0]                out_tdata
);
  import wsht_pkg::*;

  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic [PAGE_ID_W-1:0]   s1_page_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   hit_r;
  logic [HIT_TOTAL_W-1:0] hit_total_r;
  logic [SET_SIZE_W-1:0]  set_size_r;
  logic                   drop_r;
  logic [PAGE_ID_W-1:0]   drop_page_r;

  logic                   advance;
  logic                   in_acc;
  logic [PAGE_BITS-1:0]   page;
  lookup_t                look;
  logic [HIT_TOTAL_W-1:0] hit_total_nxt;
  logic [SET_SIZE_W-1:0]  set_size_nxt;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;
  assign page      = PAGE_BITS'(s1_page_r);

  wsht_window #(
    .WINDOW_MAX (WINDOW_MAX),
    .PAGE_BITS  (PAGE_BITS)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_wr_en),
    .cfg_data (cfg_wr_data),
    .step     (advance),
    .page     (page),
    .look     (look)
  );

  wsht_counters #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_counters (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_wr_en),
    .step          (advance),
    .look          (look),
    .hit_total_nxt (hit_total_nxt),
    .set_size_nxt  (set_size_nxt)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the beat payloads
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_page_r <= in_tdata;
    end
    if (advance) begin
      hit_r       <= look.hit;
      hit_total_r <= hit_total_nxt;
      set_size_r  <= set_size_nxt;
      drop_r      <= look.drop;
      drop_page_r <= look.drop_page;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, drop_page_r, drop_r, set_size_r, hit_total_r, hit_r};

endmodule

// File: tb/tb_working_set_hit_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_working_set_hit_tracker
// Self-checking bench for the working-set hit tracker: page references stream
// in under random gaps and result stalls, a local working-set model predicts
// every result beat, and the window length is rewritten between idle phases.
// ----------------------------------------------------------------------------
module tb_working_set_hit_tracker;
  import wsht_pkg::*;

  localparam int LEN_MAX     = 16;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [PAGE_ID_W-1:0]   dropped_page;
    logic                   dropped_valid;
    logic [SET_SIZE_W-1:0]  set_size;
    logic [HIT_TOTAL_W-1:0] hit_total;
    logic                   hit;
  } ws_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]     cfg_wr_data = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [PAGE_ID_W-1:0] in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [47:0]          out_tdata;
  logic                 out_hold = 1'b0;

  logic [PAGE_ID_W-1:0] page_q[$];
  ws_result_t           result_q[$];

  logic [CFG_W-1:0]     ws_len_reg = WINDOW_SIZE_RST;
  logic [PAGE_ID_W-1:0] ws_ring[LEN_MAX];
  int                   ws_count[256];
  int                   ws_fill = 0;
  logic [3:0]           ws_head = '0;
  int unsigned          ws_hits = 0;
  int                   ws_distinct = 0;

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  int refs_accepted = 0;
  int results_checked = 0;
  int drops_seen = 0;
  int settings_run = 0;
  int errors = 0;
  int cycles = 0;

  working_set_hit_tracker u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic track_reference(input logic [PAGE_ID_W-1:0] page);
    ws_result_t           r;
    int                   len;
    logic                 full;
    logic [PAGE_ID_W-1:0] old_page;
    r = '0;
    len = (ws_len_reg == 0) ? 1 : (ws_len_reg > LEN_MAX) ? LEN_MAX : int'(ws_len_reg);
    r.hit = (ws_count[page] != 0);
    full = (ws_fill >= len);
    old_page = full ? ws_ring[ws_head] : '0;
    ws_ring[4'(ws_head + ws_fill)] = page;
    if (ws_count[page] == 0) ws_distinct++;
    ws_count[page]++;
    if (full) begin
      if (ws_count[old_page] != 0) ws_count[old_page]--;
      if (ws_count[old_page] == 0) begin
        if (ws_distinct != 0) ws_distinct--;
        r.dropped_valid = 1'b1;
        r.dropped_page = old_page;
        drops_seen++;
      end
      ws_head = ws_head + 4'd1;
    end else begin
      ws_fill++;
    end
    if (r.hit && ws_hits != 32'hFFFF_FFFF) ws_hits++;
    r.hit_total = ws_hits;
    r.set_size = ws_distinct[SET_SIZE_W-1:0];
    result_q = {result_q, r};
  endtask

  task automatic report(input string field, input logic [31:0] exp_v, input logic [31:0] act_v);
    $display("%0t: mismatch on %s, expected 0x%0h, actual 0x%0h", $time, field, exp_v, act_v);
    errors++;
  endtask

  task automatic check_result(input ws_result_t got);
    ws_result_t exp_r;
    if (result_q.size() == 0) begin
      $display("%0t: result beat with nothing expected, actual 0x%0h", $time, got);
      errors++;
      return;
    end
    exp_r = result_q[0];
    result_q.delete(0);
    results_checked++;
    if (got.hit !== exp_r.hit) report("hit", exp_r.hit, got.hit);
    if (got.hit_total !== exp_r.hit_total) report("hit_total", exp_r.hit_total, got.hit_total);
    if (got.set_size !== exp_r.set_size) report("set_size", exp_r.set_size, got.set_size);
    if (got.dropped_valid !== exp_r.dropped_valid)
      report("dropped_valid", exp_r.dropped_valid, got.dropped_valid);
    if (got.dropped_page !== exp_r.dropped_page)
      report("dropped_page", exp_r.dropped_page, got.dropped_page);
  endtask

  // input driver: hold the beat until taken, then maybe idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_reference(in_tdata);
        page_q.delete(0);
        refs_accepted++;
        if ($urandom_range(0, 99) < in_idle_pct) in_gap = pick_gap();
      end
      if (in_tvalid && !in_tready) begin
        in_tvalid <= 1'b1;
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (page_q.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= page_q[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result(ws_result_t'(out_tdata[46:0]));
      if (out_hold) begin
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < out_stall_pct) begin
        out_gap = pick_gap() - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // long receiver hold while the sender keeps offering
  initial begin
    while (!(refs_accepted >= 700 && page_q.size() > 40)) @(posedge clk);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (150) @(posedge clk);
    out_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic drain();
    while (page_q.size() != 0 || result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ws_len_reg = v;
    ws_ring = '{default: '0};
    ws_count = '{default: 0};
    ws_fill = 0;
    ws_head = '0;
    ws_distinct = 0;
    settings_run++;
  endtask

  task automatic send_pages(input logic [PAGE_ID_W-1:0] list[$], input int in_pct,
                            input int out_pct);
    @(negedge clk);
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
    foreach (list[i]) page_q = {page_q, list[i]};
  endtask

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  initial begin
    logic [PAGE_ID_W-1:0] seq[$];
    logic [CFG_W-1:0]     len_val;
    int                   random_refs;
    int                   phase;
    int                   n;
    int                   pool;
    int                   len;
    logic [PAGE_ID_W-1:0] base;

    ws_count = '{default: 0};
    ws_ring = '{default: '0};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset length of four: extremes, refs, evictions
    seq = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h00, 8'h03};
    send_pages(seq, 0, 0);
    drain();

    // zero length acts as one; same page as the evicted one stays in the set
    write_window('0);
    seq = '{8'h07, 8'h07, 8'h09};
    send_pages(seq, 0, 0);
    drain();

    // oversized length saturates to the maximum
    write_window(5'd31);
    seq = '{8'hF0, 8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7,
            8'hF0, 8'hF5, 8'h80, 8'h01, 8'h7F, 8'hF0};
    send_pages(seq, 10, 10);
    drain();

    random_refs = 0;
    phase = 0;
    while (random_refs < 1800) begin
      case (phase % 7)
        0: len_val = 5'd1;
        1: len_val = 5'd16;
        2: len_val = 5'd0;
        3: len_val = 5'd31;
        4: len_val = 5'($urandom_range(17, 30));
        default: len_val = 5'($urandom_range(1, 16));
      endcase
      len = (len_val == 0) ? 1 : (len_val > LEN_MAX) ? LEN_MAX : int'(len_val);
      write_window(len_val);
      n = $urandom_range(80, 220);
      pool = ($urandom_range(0, 4) == 0) ? 256 : $urandom_range(1, 2 * len + 2);
      base = 8'($urandom_range(0, 255));
      seq.delete();
      repeat (n) seq = {seq, 8'(base + $urandom_range(0, pool - 1))};
      send_pages(seq, (phase == 3) ? 0 : pick_pct(), (phase == 3) ? 0 : pick_pct());
      drain();
      random_refs += n;
      phase++;
    end

    drain();
    $display("Covered %0d references over %0d window writes, %0d results checked",
             refs_accepted, settings_run, results_checked);
    $display("Hits counted %0d, pages dropped from the set %0d", ws_hits, drops_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: working_set_hit_tracker.f
hw/rtl/wsht_pkg.sv
hw/rtl/wsht_window.sv
hw/rtl/wsht_counters.sv
hw/rtl/working_set_hit_tracker.sv
tb/tb_working_set_hit_tracker.sv
